### rtl/aolp_pkg.sv
// Shared types and constants for the ASCII order-line parser.
// Used by aolp_parse and ascii_order_line_parser_top; no dependencies.
package aolp_pkg;

  localparam int unsigned IdW    = 20;
  localparam int unsigned NumW   = 16;
  localparam int unsigned IdAccW = IdW + 1;
  localparam int unsigned NumAccW = NumW + 1;

  localparam logic [7:0] ChrComma   = 8'h2C;
  localparam logic [7:0] ChrNewline = 8'h0A;
  localparam logic [7:0] ChrBuy     = 8'h42;
  localparam logic [7:0] ChrSell    = 8'h53;
  localparam logic [7:0] ChrZero    = 8'h30;
  localparam logic [7:0] ChrNine    = 8'h39;

  localparam logic [IdW-1:0]  MaxIdReset  = IdW'(19999);
  localparam logic [NumW-1:0] MaxQtyReset = NumW'(9999);
  localparam logic [NumW-1:0] MaxPxReset  = NumW'(299);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAX_ID  = 2'd0,
    CFG_MAX_QTY = 2'd1,
    CFG_MAX_PX  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SIDE_NONE = 2'd0,
    SIDE_BUY  = 2'd1,
    SIDE_SELL = 2'd2
  } side_e;

  // Snapshot of one closed line, before the range checks
  typedef struct packed {
    logic               good;
    logic [IdAccW-1:0]  id;
    logic               sell;
    logic [NumAccW-1:0] qty;
    logic [NumAccW-1:0] price;
  } line_t;

endpackage

### rtl/aolp_parse.sv
// Byte-level parse state of the order-line parser: field tracking,
// digit accumulation and line framing. Depends on aolp_pkg.
module aolp_parse import aolp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] text_byte_i,
  input  logic       final_byte_i,
  output logic       line_end_o,
  output line_t      line_o
);

  typedef struct packed {
    logic [2:0]         comma_count;
    logic               line_bad;
    logic               digit_seen;
    logic               prefix_open;
    logic [IdAccW-1:0]  id_accum;
    logic [NumAccW-1:0] qty_accum;
    logic [NumAccW-1:0] price_accum;
    side_e              side_code;
    logic [1:0]         side_length;
  } pstate_t;

  localparam pstate_t StateReset = '{
    comma_count: 3'd0, line_bad: 1'b0, digit_seen: 1'b0, prefix_open: 1'b1,
    id_accum: '0, qty_accum: '0, price_accum: '0,
    side_code: SIDE_NONE, side_length: 2'd0
  };

  localparam logic [IdAccW+3:0]  IdSat  = (IdAccW+4)'(1) << IdW;
  localparam logic [NumAccW+3:0] NumSat = (NumAccW+4)'(1) << NumW;

  pstate_t st_q, st_d, tb, fin_st;
  logic    is_comma, is_nl, is_digit;
  logic [3:0] digit;

  function automatic logic close_bad(pstate_t s);
    logic bad;
    bad = 1'b0;
    if (s.comma_count == 3'd1) begin
      bad = (s.side_length != 2'd1) || (s.side_code == SIDE_NONE);
    end else if (s.comma_count <= 3'd3) begin
      bad = !s.digit_seen;
    end
    return bad;
  endfunction

  // acc*10 + d, clamped at the saturation value
  function automatic logic [IdAccW-1:0] acc_id(logic [IdAccW-1:0] acc, logic [3:0] d);
    logic [IdAccW+3:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (IdAccW+4)'(d);
    return (v > IdSat) ? IdSat[IdAccW-1:0] : v[IdAccW-1:0];
  endfunction

  function automatic logic [NumAccW-1:0] acc_num(logic [NumAccW-1:0] acc, logic [3:0] d);
    logic [NumAccW+3:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (NumAccW+4)'(d);
    return (v > NumSat) ? NumSat[NumAccW-1:0] : v[NumAccW-1:0];
  endfunction

  assign is_comma = (text_byte_i == ChrComma);
  assign is_nl    = (text_byte_i == ChrNewline);
  assign is_digit = (text_byte_i >= ChrZero) && (text_byte_i <= ChrNine);
  assign digit    = text_byte_i[3:0];

  always_comb begin
    tb = st_q;
    if (is_comma) begin
      if (close_bad(st_q)) tb.line_bad = 1'b1;
      if (st_q.comma_count >= 3'd3) begin
        tb.line_bad    = 1'b1;
        tb.comma_count = 3'd4;
      end else begin
        tb.comma_count = st_q.comma_count + 3'd1;
      end
      tb.digit_seen  = 1'b0;
      tb.prefix_open = 1'b1;
    end else if (st_q.comma_count == 3'd1) begin
      if (st_q.side_length == 2'd0) begin
        tb.side_code = (text_byte_i == ChrBuy)  ? SIDE_BUY  :
                       (text_byte_i == ChrSell) ? SIDE_SELL : SIDE_NONE;
      end
      if (st_q.side_length < 2'd2) tb.side_length = st_q.side_length + 2'd1;
    end else if (st_q.comma_count <= 3'd3) begin
      if (st_q.prefix_open && is_digit) begin
        tb.digit_seen = 1'b1;
        unique case (st_q.comma_count)
          3'd0:    tb.id_accum    = acc_id(st_q.id_accum, digit);
          3'd2:    tb.qty_accum   = acc_num(st_q.qty_accum, digit);
          default: tb.price_accum = acc_num(st_q.price_accum, digit);
        endcase
      end else begin
        tb.prefix_open = 1'b0;
      end
    end
  end

  // A newline ends the line without being parsed as text
  assign fin_st     = is_nl ? st_q : tb;
  assign line_end_o = is_nl || final_byte_i;

  always_comb begin
    line_o.good  = !(fin_st.line_bad || close_bad(fin_st)) && (fin_st.comma_count == 3'd3);
    line_o.id    = fin_st.id_accum;
    line_o.sell  = (fin_st.side_code == SIDE_SELL);
    line_o.qty   = fin_st.qty_accum;
    line_o.price = fin_st.price_accum;
  end

  always_comb begin
    st_d = st_q;
    if (take_i) st_d = line_end_o ? StateReset : tb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateReset;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

### rtl/ascii_order_line_parser_top.sv
// Top level of the ASCII order-line parser: config registers, closed-line
// stage, range check and output register. Depends on aolp_pkg, aolp_parse.
//
//  channel | signals                               | carries
//  --------+---------------------------------------+---------------------------
//  in      | in_valid_i / in_ready_o               | text_byte_i, final_byte_i
//  out     | out_valid_o / out_ready_i             | order_id/side/quantity/price
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i       | max_order_id/quantity/price
//
// One byte is taken per clock while in_ready_o is high. A line's order passes
// from its closing byte through the closed-line register and then the output
// register. The closed-line register and output register form a two-deep
// queue, so input stalls only when both are full and the output is held.
// Reset clears the parse state and loads the default limits.
module ascii_order_line_parser_top import aolp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      text_byte_i,
  input  logic            final_byte_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [IdW-1:0]  order_id_o,
  output logic            order_side_o,
  output logic [NumW-1:0] order_quantity_o,
  output logic [NumW-1:0] order_price_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [IdW-1:0]  cfg_data_i
);

  logic [IdW-1:0]  max_id_q;
  logic [NumW-1:0] max_qty_q, max_px_q;

  logic  take, line_end, cl_move, ok;
  line_t line, cl_q;
  logic  cl_valid_q, out_valid_q;
  logic [IdW-1:0]  id_q;
  logic            side_q;
  logic [NumW-1:0] qty_q, px_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_id_q  <= MaxIdReset;
      max_qty_q <= MaxQtyReset;
      max_px_q  <= MaxPxReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_ID:  max_id_q  <= cfg_data_i;
        CFG_MAX_QTY: max_qty_q <= cfg_data_i[NumW-1:0];
        CFG_MAX_PX:  max_px_q  <= cfg_data_i[NumW-1:0];
        default: ;
      endcase
    end
  end

  assign cl_move    = !out_valid_q || out_ready_i;
  assign in_ready_o = !cl_valid_q || cl_move;
  assign take       = in_valid_i && in_ready_o;

  aolp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .text_byte_i  (text_byte_i),
    .final_byte_i (final_byte_i),
    .line_end_o   (line_end),
    .line_o       (line)
  );

  // Hold the closed line until the output register can take it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cl_valid_q <= 1'b0;
    end else if (take && line_end) begin
      cl_valid_q <= 1'b1;
    end else if (cl_move) begin
      cl_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && line_end) cl_q <= line;
  end

  assign ok = cl_q.good
           && (cl_q.id <= {1'b0, max_id_q})
           && (cl_q.qty != '0) && (cl_q.qty <= {1'b0, max_qty_q})
           && (cl_q.price != '0) && (cl_q.price <= {1'b0, max_px_q});

  // Drop lines that fail the checks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cl_move) begin
      out_valid_q <= cl_valid_q && ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cl_move && cl_valid_q && ok) begin
      id_q   <= cl_q.id[IdW-1:0];
      side_q <= cl_q.sell;
      qty_q  <= cl_q.qty[NumW-1:0];
      px_q   <= cl_q.price[NumW-1:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign order_id_o       = id_q;
  assign order_side_o     = side_q;
  assign order_quantity_o = qty_q;
  assign order_price_o    = px_q;

  a_qty_px_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (order_quantity_o != '0) && (order_price_o != '0))
    else $error("order with zero quantity or price");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> cl_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a full queue");

  a_cl_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cl_valid_q && !cl_move |=> cl_valid_q && $stable(cl_q))
    else $error("closed line lost while output stalled");

endmodule

### test/tb_ascii_order_line_parser_top.sv
// Testbench for ascii_order_line_parser_top: drives order text byte by byte and
// checks every emitted order against an in-bench line parser model.
// Depends on aolp_pkg and the parser RTL only.
module tb_ascii_order_line_parser_top;
  import aolp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic            side;
    logic [NumW-1:0] qty;
    logic [NumW-1:0] px;
  } order_t;

  // Tracks the parse of the current line and holds the orders still owed.
  class order_tracker;
    int unsigned lim_id, lim_qty, lim_px;
    int unsigned n_commas, id_val, qty_val, px_val, side_chars;
    bit          bad_line, have_digit, in_prefix;
    side_e       side_seen;
    order_t      orders_due[$];
    int          errors;

    function new();
      lim_id  = 32'(MaxIdReset);
      lim_qty = 32'(MaxQtyReset);
      lim_px  = 32'(MaxPxReset);
      errors  = 0;
      start_line();
    endfunction

    function void set_limit(cfg_idx_e idx, int unsigned val);
      case (idx)
        CFG_MAX_ID:  lim_id  = val & 32'hFFFFF;
        CFG_MAX_QTY: lim_qty = val & 32'hFFFF;
        CFG_MAX_PX:  lim_px  = val & 32'hFFFF;
        default: ;
      endcase
    endfunction

    function void start_line();
      n_commas   = 0;
      bad_line   = 0;
      id_val     = 0;
      qty_val    = 0;
      px_val     = 0;
      side_seen  = SIDE_NONE;
      side_chars = 0;
      have_digit = 0;
      in_prefix  = 1;
    endfunction

    function int unsigned push_digit(int unsigned acc, int unsigned d, int unsigned cap);
      int unsigned v;
      v = acc * 10 + d;
      return (v > cap) ? cap : v;
    endfunction

    // Validate the field being closed by a comma or by the line end.
    function void finish_field();
      if (n_commas == 1) begin
        if (side_chars != 1 || side_seen == SIDE_NONE) bad_line = 1;
      end else if (n_commas <= 3) begin
        if (!have_digit) bad_line = 1;
      end
    endfunction

    function void close_line();
      order_t o;
      finish_field();
      if (!bad_line && n_commas == 3 && id_val <= lim_id &&
          qty_val >= 1 && qty_val <= lim_qty && px_val >= 1 && px_val <= lim_px) begin
        o.id   = IdW'(id_val);
        o.side = (side_seen == SIDE_SELL);
        o.qty  = NumW'(qty_val);
        o.px   = NumW'(px_val);
        orders_due.insert(orders_due.size(), o);
      end
      start_line();
    endfunction

    function void consume(logic [7:0] b);
      int unsigned d;
      if (b == ChrComma) begin
        finish_field();
        if (n_commas >= 3) begin
          bad_line = 1;
          n_commas = 4;
        end else begin
          n_commas++;
        end
        have_digit = 0;
        in_prefix  = 1;
        return;
      end
      if (n_commas == 1) begin
        if (side_chars == 0)
          side_seen = (b == ChrBuy) ? SIDE_BUY : (b == ChrSell) ? SIDE_SELL : SIDE_NONE;
        if (side_chars < 2) side_chars++;
        return;
      end
      if (n_commas > 3) return;
      if (in_prefix && b >= ChrZero && b <= ChrNine) begin
        d = 32'(b) - 32'(ChrZero);
        have_digit = 1;
        case (n_commas)
          0:       id_val  = push_digit(id_val, d, 32'h100000);
          2:       qty_val = push_digit(qty_val, d, 32'h10000);
          default: px_val  = push_digit(px_val, d, 32'h10000);
        endcase
      end else begin
        in_prefix = 0;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      if (b == ChrNewline) begin
        close_line();
        return;
      end
      consume(b);
      if (fin) close_line();
    endfunction

    function void check_order(order_t got);
      order_t want;
      if (orders_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("order mismatch: unexpected id=%0d side=%0d qty=%0d px=%0d",
                   got.id, got.side, got.qty, got.px);
        return;
      end
      want = orders_due.pop_front();
      if (got.id !== want.id || got.side !== want.side ||
          got.qty !== want.qty || got.px !== want.px) begin
        errors++;
        if (errors <= 10)
          $display("order mismatch: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                   want.id, want.side, want.qty, want.px, got.id, got.side, got.qty, got.px);
      end
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [7:0]      text_byte_i = '0;
  logic            final_byte_i = 1'b0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [IdW-1:0]  order_id_o;
  logic            order_side_o;
  logic [NumW-1:0] order_quantity_o;
  logic [NumW-1:0] order_price_o;
  logic            cfg_we_i = 1'b0;
  logic [1:0]      cfg_idx_i = CFG_MAX_ID;
  logic [IdW-1:0]  cfg_data_i = '0;

  order_tracker tracker;
  logic [7:0]   line_buf[$];
  int           bytes_sent = 0;
  bit           no_gaps = 0;
  bit           no_stalls = 0;
  int           hold_asks = 0;

  ascii_order_line_parser_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .text_byte_i      (text_byte_i),
    .final_byte_i     (final_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .order_id_o       (order_id_o),
    .order_side_o     (order_side_o),
    .order_quantity_o (order_quantity_o),
    .order_price_o    (order_price_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Append one byte to the line being built.
  function automatic void add_byte(logic [7:0] b);
    line_buf.insert(line_buf.size(), b);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    bit took;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    text_byte_i  <= b;
    final_byte_i <= fin;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    tracker.note_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic send_line(input bit fin_last);
    foreach (line_buf[i]) send_byte(line_buf[i], fin_last && (i == line_buf.size() - 1));
  endtask

  task automatic send_text(input string s, input bit fin_last);
    line_buf.delete();
    foreach (s[i]) add_byte(s[i]);
    send_line(fin_last);
  endtask

  // Append a number field aimed around the given limit.
  function automatic void add_number(int unsigned lim);
    int unsigned v;
    int          r;
    string       s;
    string       junk;
    junk = "x. -+e#B";
    r = $urandom_range(0, 24);
    if (r == 0) begin
      add_byte(junk[$urandom_range(0, 7)]);
      return;
    end
    case (r)
      1:       v = 0;
      2:       v = lim;
      3:       v = lim + 1;
      4:       v = $urandom;
      5:       v = $urandom_range(0, lim + 20);
      default: v = (lim == 0) ? 0 : $urandom_range(1, lim);
    endcase
    if ($urandom_range(0, 5) == 0) add_byte(ChrZero);
    s = $sformatf("%0d", v);
    foreach (s[i]) add_byte(s[i]);
    // trailing junk ends the digit prefix; a later digit must be ignored
    if ($urandom_range(0, 6) == 0) begin
      add_byte(junk[$urandom_range(0, 7)]);
      if ($urandom_range(0, 1)) add_byte(ChrZero + 8'($urandom_range(0, 9)));
    end
  endfunction

  function automatic void add_field(int unsigned lim, bit signed_first);
    string signs;
    signs = "-+ ";
    if (signed_first) add_byte(signs[$urandom_range(0, 2)]);
    add_number(lim);
  endfunction

  function automatic void build_line(output bit fin_last);
    int k, sign_at, extra, t;
    string side_s;
    line_buf.delete();
    k       = $urandom_range(0, 99);
    sign_at = -1;
    extra   = 0;
    side_s  = $urandom_range(0, 1) ? "B" : "S";
    if (k >= 88) begin
      repeat ($urandom_range(0, 12)) add_byte(8'($urandom_range(0, 255)));
    end else begin
      if (k >= 65 && k < 72) begin
        case ($urandom_range(0, 6))
          0:       side_s = "";
          1:       side_s = "BB";
          2:       side_s = "SB";
          3:       side_s = "X";
          4:       side_s = "b";
          5:       side_s = "s";
          default: side_s = " B";
        endcase
      end else if (k >= 72 && k < 78) begin
        sign_at = $urandom_range(0, 2);
      end else if (k >= 78) begin
        extra = $urandom_range(0, 1) ? -1 : $urandom_range(1, 2);
      end
      add_field(tracker.lim_id, sign_at == 0);
      add_byte(ChrComma);
      foreach (side_s[i]) add_byte(side_s[i]);
      add_byte(ChrComma);
      add_field(tracker.lim_qty, sign_at == 1);
      if (extra >= 0) begin
        add_byte(ChrComma);
        add_field(tracker.lim_px, sign_at == 2);
      end
      repeat ((extra > 0) ? extra : 0) begin
        add_byte(ChrComma);
        add_number(tracker.lim_px);
      end
    end
    t = $urandom_range(0, 9);
    if (t >= 7 && line_buf.size() > 0) begin
      fin_last = 1;
    end else begin
      add_byte(ChrNewline);
      fin_last = (t == 6);
    end
  endfunction

  // Drop valid and wait until every owed order is out, plus pipeline slack.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.orders_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limits(input int unsigned id_lim, qty_lim, px_lim);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MAX_ID;
    cfg_data_i <= IdW'(id_lim);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MAX_QTY;
    cfg_data_i <= IdW'(qty_lim & 32'hFFFF);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MAX_PX;
    cfg_data_i <= IdW'(px_lim & 32'hFFFF);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    tracker.set_limit(CFG_MAX_ID, id_lim);
    tracker.set_limit(CFG_MAX_QTY, qty_lim);
    tracker.set_limit(CFG_MAX_PX, px_lim);
  endtask

  task automatic run_phase(input int unsigned id_lim, qty_lim, px_lim, input int nbytes,
                           input bit burst, input bit hold);
    int start;
    bit fin;
    start = bytes_sent;
    drain();
    write_limits(id_lim, qty_lim, px_lim);
    no_gaps   = burst;
    no_stalls = burst;
    if (hold) hold_asks++;
    while (bytes_sent - start < nbytes) begin
      build_line(fin);
      send_line(fin);
    end
  endtask

  // Order sink: random back-pressure, one long hold-off on request.
  initial begin
    order_t got;
    bit     took;
    int     stall;
    int     hold_done;
    hold_done = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_done != hold_asks) begin
        stall     = 250;
        hold_done = hold_asks;
      end else begin
        stall = no_stalls ? 0 : $urandom_range(0, 6);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        took     = out_valid_o;
        got.id   = order_id_o;
        got.side = order_side_o;
        got.qty  = order_quantity_o;
        got.px   = order_price_o;
        @(posedge clk_i);
      end while (!took);
      tracker.check_order(got);
    end
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    tracker = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed lines at the reset limits
    send_text("0,B,1,1\n", 0);
    send_text("19999,S,9999,299\n", 1);
    send_text("-5,S,5,5\n", 0);
    send_text(" 5,B,5,5\n", 0);
    send_text("\n", 0);
    send_text("1,B,2\n", 0);
    send_text("1,B,2,3,4\n", 0);
    send_text("99999999,S,1,1\n", 0);
    send_text("7,S,3,30x9", 1);

    run_phase(1048575, 65535, 65535, 160, 1, 0);
    run_phase(0, 1, 1, 140, 0, 0);
    // zero quantity limit: nothing may come out
    run_phase(19999, 0, 299, 80, 0, 0);
    run_phase($urandom_range(0, 999), $urandom_range(1, 65535), $urandom_range(1, 999),
              160, 1, 1);
    while (bytes_sent < 1350)
      run_phase($urandom_range(0, 1) ? $urandom_range(0, 1048575) : $urandom_range(0, 999),
                $urandom_range(1, 65535), $urandom_range(1, 65535), 150,
                $urandom_range(0, 3) == 0, 0);

    drain();
    repeat (8) @(posedge clk_i);
    if (tracker.orders_due.size() != 0) tracker.errors++;
    if (tracker.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### ascii_order_line_parser_top.f
rtl/aolp_pkg.sv
rtl/aolp_parse.sv
rtl/ascii_order_line_parser_top.sv
test/tb_ascii_order_line_parser_top.sv
